/* src/text_console_writer_unit_assert.svh */
// Assertion helpers for the console writer back end.
// They expect clk_i and rst_ni to be visible in the module that uses them.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* src/tcw_pkg.sv */
package tcw_pkg;

  // Field widths of the request and response items.
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned STYLE_W    = 8;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned OFFSET_W   = 11;

  // Widths that cover the largest supported screen (64 rows by 256 columns).
  localparam int unsigned ROW_MAX_W = 6;
  localparam int unsigned COL_MAX_W = 8;
  localparam int unsigned IDX_MAX_W = 14;

  // Request type codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_SET   = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

  // Special characters and the attribute used until the first configuration write.
  localparam logic [CHAR_W-1:0]  CH_NULL     = 8'd0;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
  localparam logic [STYLE_W-1:0] STYLE_RESET = 8'd15;

  // Entries in the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation decided by the front end.
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PUT     = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_SET     = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [CHAR_W-1:0]     char_code;
    logic [STYLE_W-1:0]    style;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
  } req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CHAR_W-1:0]   cell_char;
    logic [STYLE_W-1:0]  cell_style;
    logic                scrolled;
  } rsp_t;

  // Classified command with the position already saturated and flattened.
  typedef struct packed {
    op_e                  op;
    logic [CHAR_W-1:0]    char_code;
    logic [STYLE_W-1:0]   style;
    logic [ROW_MAX_W-1:0] row;
    logic [COL_MAX_W-1:0] col;
    logic [IDX_MAX_W-1:0] idx;
  } cmd_t;

endpackage

/* src/tcw_if.sv */
// Request channel.
interface tcw_req_if
  import tcw_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Response channel.
interface tcw_rsp_if
  import tcw_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/tcw_front.sv */
module tcw_front
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  tcw_req_if.sink    req_i,
  input  logic       init_i,
  output cmd_t       cmd_o,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i
);

  logic [ROW_MAX_W-1:0] row_sat;
  logic [COL_MAX_W-1:0] col_sat;

  // No item is taken while the store is being cleared after reset.
  assign req_i.ready = cmd_ready_i && !init_i;
  assign cmd_valid_o = req_i.valid && !init_i;

  // Clamp the requested position to the screen.
  always_comb begin
    if (ROW_MAX_W'(req_i.payload.row) > ROW_MAX_W'(ROWS - 1)) begin
      row_sat = ROW_MAX_W'(ROWS - 1);
    end else begin
      row_sat = ROW_MAX_W'(req_i.payload.row);
    end
    if (COL_MAX_W'(req_i.payload.col) > COL_MAX_W'(COLS - 1)) begin
      col_sat = COL_MAX_W'(COLS - 1);
    end else begin
      col_sat = COL_MAX_W'(req_i.payload.col);
    end
  end

  // Classify the item into one operation for the back end.
  always_comb begin
    cmd_o.char_code = req_i.payload.char_code;
    cmd_o.style     = req_i.payload.style;
    cmd_o.row       = row_sat;
    cmd_o.col       = col_sat;
    cmd_o.idx       = IDX_MAX_W'(32'(row_sat) * COLS + 32'(col_sat));
    unique case (req_i.payload.req_type)
      REQ_PUT: begin
        if (req_i.payload.char_code == CH_NULL) begin
          cmd_o.op = OP_NOP;
        end else if (req_i.payload.char_code == CH_NEWLINE) begin
          cmd_o.op = OP_NEWLINE;
        end else begin
          cmd_o.op = OP_PUT;
        end
      end
      REQ_CLEAR: cmd_o.op = OP_CLEAR;
      REQ_SET:   cmd_o.op = OP_SET;
      REQ_READ:  cmd_o.op = OP_READ;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

/* src/tcw_queue.sv */
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            buf_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/tcw_back.sv */
`include "text_console_writer_unit_assert.svh"

module tcw_back
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  logic               cfg_we_i,
  input  logic [STYLE_W-1:0] cfg_wdata_i,
  output logic               init_o,
  tcw_rsp_if.source          rsp_o
);

  localparam int unsigned Cells       = ROWS * COLS;
  localparam int unsigned CW          = $clog2(Cells);
  localparam int unsigned RW          = $clog2(ROWS);
  localparam int unsigned CLW         = $clog2(COLS);
  localparam int unsigned LastRowBase = (ROWS - 1) * COLS;
  localparam int unsigned CellW       = CHAR_W + STYLE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_BLANK = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [RW-1:0]      cur_row_q, cur_row_d;
  logic [CLW-1:0]     cur_col_q, cur_col_d;
  logic [CW-1:0]      cur_off_q, cur_off_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [STYLE_W-1:0] blank_style_q, blank_style_d;
  logic [STYLE_W-1:0] default_style_q;
  logic               emit_q, emit_d;
  logic               scroll_q, scroll_d;
  logic               init_q, init_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic [CellW-1:0]   mem [Cells];
  logic [CellW-1:0]   rd_data_q;
  logic               mem_we;
  logic [CW-1:0]      mem_waddr;
  logic [CellW-1:0]   mem_wdata;
  logic [CW-1:0]      mem_raddr;

  logic               cmd_pop;
  logic               emit_now;
  logic               do_scroll;
  logic               ptr_last;
  logic               row_last;
  logic               col_last;

  assign cmd_ready_o = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign cmd_pop     = cmd_valid_i && cmd_ready_o;
  assign ptr_last    = ptr_q == CW'(Cells - 1);
  assign row_last    = cur_row_q == RW'(ROWS - 1);
  assign col_last    = cur_col_q == CLW'(COLS - 1);
  assign init_o      = init_q;

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Command execution, store sweeps and result formation.
  always_comb begin
    state_d       = state_q;
    cur_row_d     = cur_row_q;
    cur_col_d     = cur_col_q;
    cur_off_d     = cur_off_q;
    ptr_d         = ptr_q;
    blank_style_d = blank_style_q;
    emit_d        = emit_q;
    scroll_d      = scroll_q;
    init_d        = init_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    rsp_d         = rsp_q;
    mem_we        = 1'b0;
    mem_waddr     = cur_off_q;
    mem_wdata     = {cmd_i.style, cmd_i.char_code};
    mem_raddr     = ptr_q;
    emit_now      = 1'b0;
    do_scroll     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        mem_raddr = cmd_i.idx[CW-1:0];
        if (cmd_pop) begin
          unique case (cmd_i.op)
            OP_PUT: begin
              mem_we = 1'b1;
              if (col_last && row_last) begin
                do_scroll = 1'b1;
              end else begin
                emit_now  = 1'b1;
                cur_off_d = cur_off_q + CW'(1);
                if (col_last) begin
                  cur_row_d = cur_row_q + RW'(1);
                  cur_col_d = '0;
                end else begin
                  cur_col_d = cur_col_q + CLW'(1);
                end
              end
            end
            OP_NEWLINE: begin
              if (row_last) begin
                do_scroll = 1'b1;
              end else begin
                emit_now  = 1'b1;
                cur_row_d = cur_row_q + RW'(1);
                cur_col_d = '0;
                cur_off_d = cur_off_q + CW'(COLS) - CW'(cur_col_q);
              end
            end
            OP_CLEAR: begin
              cur_row_d     = '0;
              cur_col_d     = '0;
              cur_off_d     = '0;
              ptr_d         = '0;
              blank_style_d = default_style_q;
              emit_d        = 1'b1;
              scroll_d      = 1'b0;
              state_d       = ST_BLANK;
            end
            OP_SET: begin
              emit_now  = 1'b1;
              cur_row_d = cmd_i.row[RW-1:0];
              cur_col_d = cmd_i.col[CLW-1:0];
              cur_off_d = cmd_i.idx[CW-1:0];
            end
            OP_READ: begin
              state_d = ST_READ;
            end
            default: begin
              emit_now = 1'b1;
            end
          endcase
        end

        // A scroll copies every row up by one, then blanks the bottom row.
        if (do_scroll) begin
          cur_row_d     = RW'(ROWS - 1);
          cur_col_d     = '0;
          cur_off_d     = CW'(LastRowBase);
          ptr_d         = CW'(COLS);
          blank_style_d = default_style_q;
          emit_d        = 1'b1;
          scroll_d      = 1'b1;
          state_d       = ST_COPY;
        end

        if (emit_now) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{cursor_offset: OFFSET_W'(cur_off_d), cell_char: '0,
                          cell_style: '0, scrolled: 1'b0};
        end
      end

      ST_READ: begin
        rsp_valid_d = 1'b1;
        rsp_d       = '{cursor_offset: OFFSET_W'(cur_off_q),
                        cell_char: rd_data_q[CHAR_W-1:0],
                        cell_style: rd_data_q[CellW-1:CHAR_W], scrolled: 1'b0};
        state_d     = ST_IDLE;
      end

      // Read one row ahead, write the cell read in the previous cycle.
      ST_COPY: begin
        mem_raddr = ptr_q;
        mem_we    = ptr_q != CW'(COLS);
        mem_waddr = ptr_q - CW'(COLS + 1);
        mem_wdata = rd_data_q;
        if (ptr_last) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = CW'(LastRowBase - 1);
        mem_wdata = rd_data_q;
        ptr_d     = CW'(LastRowBase);
        state_d   = ST_BLANK;
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {blank_style_q, CH_SPACE};
        if (ptr_last) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          emit_d  = 1'b0;
          if (emit_q) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{cursor_offset: OFFSET_W'(cur_off_q), cell_char: '0,
                            cell_style: '0, scrolled: scroll_q};
          end
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state; reset starts a blanking pass in the reset attribute.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_BLANK;
      cur_row_q       <= '0;
      cur_col_q       <= '0;
      cur_off_q       <= '0;
      ptr_q           <= '0;
      blank_style_q   <= STYLE_RESET;
      default_style_q <= STYLE_RESET;
      emit_q          <= 1'b0;
      scroll_q        <= 1'b0;
      init_q          <= 1'b1;
      rsp_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cur_row_q     <= cur_row_d;
      cur_col_q     <= cur_col_d;
      cur_off_q     <= cur_off_d;
      ptr_q         <= ptr_d;
      blank_style_q <= blank_style_d;
      emit_q        <= emit_d;
      scroll_q      <= scroll_d;
      init_q        <= init_d;
      rsp_valid_q   <= rsp_valid_d;
      if (cfg_we_i) begin
        default_style_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Screen store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  `TCW_ASSERT(a_cursor_consistent,
    32'(cur_off_q) == 32'(cur_row_q) * COLS + 32'(cur_col_q),
    "cursor offset does not match row and column")
  `TCW_ASSERT(a_cursor_in_range,
    (32'(cur_row_q) < ROWS) && (32'(cur_col_q) < COLS),
    "cursor left the screen")
  `TCW_ASSERT(a_slot_free_when_busy,
    (state_q != ST_IDLE) |-> !rsp_valid_q,
    "result slot occupied while a command is still running")
  `TCW_ASSERT(a_copy_below_last_row,
    ((state_q == ST_COPY) && mem_we) |-> (mem_waddr < CW'(LastRowBase)),
    "scroll copy wrote into the bottom row")
  `TCW_ASSERT_NEXT(a_no_result_after_reset, init_q, !rsp_valid_q,
    "result produced by the reset clearing pass")

endmodule

/* src/text_console_writer_unit.sv */
// Character-cell text console with a cursor, ROWS x COLS cells of char and attribute.
// Requests arrive on req_i (valid/ready); each accepted item gives exactly one
// item on rsp_o carrying the cursor offset, the cell read (reads only) and a
// scroll flag. cfg_we_i/cfg_wdata_i set the attribute used for blanked cells.
// Items pass through a two-entry command queue to the execution engine, so the
// request side keeps accepting while a result waits to be taken.
// Put, newline, set cursor and ignored characters are answered through the queue
// entry and the result register and sustain one item per cycle while rsp_o takes
// each result; a read also passes ST_READ for the registered store read. Clear
// writes one cell per cycle over all ROWS*COLS cells; a scroll copies ROWS-1
// rows through the single store port, then the bottom row is blanked.
// After reset the store is blanked in attribute 15; no request is accepted
// during that pass, but configuration writes are taken. When rsp_o stalls, the
// result is held, the queue fills and req_i.ready drops once it is full.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcw_req_if.sink            req_i,
  tcw_rsp_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [STYLE_W-1:0] cfg_wdata_i
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;
  logic init;

  // Classification of incoming items.
  tcw_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .req_i       (req_i),
    .init_i      (init),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // Decoupling queue between front and back.
  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // Execution engine with the screen store.
  tcw_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .init_o      (init),
    .rsp_o       (rsp_o)
  );

endmodule
